### design/lmph_pkg.sv
// ----------------------------------------------------------------------------
// lmph_pkg: shared types and constants of the peak-hold level meter
// Field widths, register codes, reset values and the structs passed between
// the meter pipeline stages.
// ----------------------------------------------------------------------------
package lmph_pkg;

  localparam int DEF_CHANNELS        = 8;
  localparam int DEF_SEGMENTS        = 14;
  localparam int DEF_LOG_TABLE_DEPTH = 256;

  localparam int CHAN_W     = 3;
  localparam int TIME_W     = 32;
  localparam int AMP_W      = 16;
  localparam int LEVEL_W    = 13;
  localparam int SEG_W      = 4;
  localparam int RATE_W     = 16;
  localparam int HOLD_W     = 16;
  localparam int FLOOR_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // log2 attenuation in Q16 (below 16 octaves), dB attenuation in Q16
  localparam int LOG2_W      = 20;
  localparam int DB_W        = 19;
  localparam int ATTDB_W     = 23;
  localparam int SCALED_W    = 19;
  localparam int RECIP_SHIFT = 27;
  localparam int RECIP_W     = 28;

  // 20*log10(2) in Q16
  localparam logic [DB_W-1:0]    DB_PER_OCTAVE = 19'd394566;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL    = 13'd4096;

  localparam logic [RATE_W-1:0]  RESET_FALL_RATE = 16'd8389;
  localparam logic [HOLD_W-1:0]  RESET_PEAK_HOLD = 16'd1500;
  localparam logic [FLOOR_W-1:0] RESET_FLOOR_DB  = 7'd48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FALL_RATE = 2'd0,
    REG_PEAK_HOLD = 2'd1,
    REG_FLOOR_DB  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [RATE_W-1:0]  fall_rate;
    logic [HOLD_W-1:0]  peak_hold_ms;
    logic [FLOOR_W-1:0] floor_db;
  } cfg_t;

  // sideband that travels with a sample through the height pipeline
  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [TIME_W-1:0] now_ms;
  } tag_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [LEVEL_W-1:0] bar;
    logic [LEVEL_W-1:0] peak;
    logic               visible;
  } meter_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [LEVEL_W-1:0] bar;
    logic [LEVEL_W-1:0] peak;
    logic [SEG_W-1:0]   lit;
    logic [SEG_W-1:0]   peak_seg;
    logic               visible;
  } result_t;

endpackage

### design/lmph_intf.sv
// ----------------------------------------------------------------------------
// lmph_intf: channel interfaces of the level meter
// Sample input, meter result output and register write channels.
// ----------------------------------------------------------------------------
interface lmph_sample_if;
  logic                       valid;
  logic                       ready;
  logic [lmph_pkg::CHAN_W-1:0] channel;
  logic [lmph_pkg::TIME_W-1:0] now_ms;
  logic [lmph_pkg::AMP_W-1:0]  amplitude;

  modport source (output valid, channel, now_ms, amplitude, input ready);
  modport sink   (input valid, channel, now_ms, amplitude, output ready);
endinterface

interface lmph_meter_if;
  logic                        valid;
  logic                        ready;
  logic [lmph_pkg::CHAN_W-1:0]  channel_out;
  logic [lmph_pkg::LEVEL_W-1:0] bar_level;
  logic [lmph_pkg::LEVEL_W-1:0] peak_level;
  logic [lmph_pkg::SEG_W-1:0]   lit_segments;
  logic [lmph_pkg::SEG_W-1:0]   peak_segment;
  logic                        peak_visible;

  modport source (output valid, channel_out, bar_level, peak_level, lit_segments,
                  peak_segment, peak_visible, input ready);
  modport sink   (input valid, channel_out, bar_level, peak_level, lit_segments,
                  peak_segment, peak_visible, output ready);
endinterface

interface lmph_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lmph_pkg::CFG_IDX_W-1:0]  index;
  logic [lmph_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/lmph_height.sv
// ----------------------------------------------------------------------------
// lmph_height: amplitude to bar height
// Three stages: log2 lookup, dB scaling against the floor, divide by the floor
// through a reciprocal table. Output is the fresh height 0..4096.
// ----------------------------------------------------------------------------
module lmph_height #(
  parameter int LOG_TABLE_DEPTH = lmph_pkg::DEF_LOG_TABLE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  lmph_pkg::tag_t               in_tag,
  input  logic [lmph_pkg::AMP_W-1:0]   amplitude,
  input  logic [lmph_pkg::FLOOR_W-1:0] floor_db,
  output logic                         out_valid,
  output lmph_pkg::tag_t               out_tag,
  output logic [lmph_pkg::LEVEL_W-1:0] fresh
);
  import lmph_pkg::*;

  localparam int IdxW     = $clog2(LOG_TABLE_DEPTH);
  localparam int MulW     = LOG2_W + DB_W;
  localparam int RecMulW  = SCALED_W + RECIP_W;
  localparam int QuotW    = RecMulW - RECIP_SHIFT;
  localparam int SumW     = ATTDB_W + 1;
  localparam int TopIdx   = (32767 * LOG_TABLE_DEPTH) / 32768;

  // log2(1 + x) in Q16 by repeated squaring of a Q30 value
  function automatic logic [15:0] frac_log2(input logic [63:0] seed);
    logic [63:0] x;
    logic [15:0] r;
    x = seed;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x    = x >> 1;
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

  localparam logic [63:0] TopSeed =
    (64'd1 << 30) + ((64'(TopIdx) << 30) / LOG_TABLE_DEPTH);
  // log2 of full scale (65535)
  localparam logic [LOG2_W-1:0] FullL2 = {4'd15, 16'h0} + LOG2_W'(frac_log2(TopSeed));

  logic [15:0]        log_tab   [LOG_TABLE_DEPTH];
  logic [RECIP_W-1:0] recip_tab [2**FLOOR_W];

  for (genvar gi = 0; gi < LOG_TABLE_DEPTH; gi++) begin : g_log
    localparam logic [63:0] Seed  = (64'd1 << 30) + ((64'(gi) << 30) / LOG_TABLE_DEPTH);
    localparam logic [15:0] Entry = frac_log2(Seed);
    assign log_tab[gi] = Entry;
  end

  // ceil(2^27 / f); a floor of zero counts as 1 dB, so entry 0 equals entry 1
  for (genvar gf = 0; gf < 2**FLOOR_W; gf++) begin : g_recip
    localparam int Div = (gf == 0) ? 1 : gf;
    localparam logic [RECIP_W-1:0] Recip =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(Div) - 64'd1) / 64'(Div));
    assign recip_tab[gf] = Recip;
  end

  // ---- stage 1: log2 of the amplitude ----
  logic [3:0]        msb;
  logic [15:0]       mant;
  logic [IdxW-1:0]   idx;
  logic [LOG2_W-1:0] l2;
  logic [LOG2_W-1:0] att;

  always_comb begin
    msb = '0;
    for (int b = 1; b < AMP_W; b++) begin
      if (amplitude[b]) begin
        msb = 4'(b);
      end
    end
    mant = amplitude << (4'd15 - msb);
    idx  = IdxW'((32'(mant[14:0]) * LOG_TABLE_DEPTH) >> 15);
    l2   = {msb, 16'h0} + LOG2_W'(log_tab[idx]);
    att  = (l2 >= FullL2) ? '0 : FullL2 - l2;
  end

  logic              s2_valid;
  tag_t              s2_tag;
  logic [LOG2_W-1:0] s2_att;
  logic              s2_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_tag  <= in_tag;
      s2_att  <= att;
      s2_zero <= (amplitude == '0);
    end
  end

  // ---- stage 2: attenuation in dB, distance above the floor ----
  logic [FLOOR_W-1:0]  f;
  logic [ATTDB_W-1:0]  fq;
  logic [MulW-1:0]     db_prod;
  logic [ATTDB_W-1:0]  attdb;
  logic                below;
  logic [SumW-1:0]     sum;
  logic [SCALED_W-1:0] scaled;

  always_comb begin
    f       = (floor_db == '0) ? FLOOR_W'(1) : floor_db;
    fq      = {f, 16'h0};
    db_prod = MulW'(s2_att) * MulW'(DB_PER_OCTAVE);
    attdb   = db_prod[MulW-1:16];
    below   = (attdb >= fq);
    // round((fq - attdb) * 4096 / fq) == floor(((fq - attdb) + 8f) / 16 / f)
    sum     = SumW'(fq - attdb) + SumW'({f, 3'b000});
    scaled  = sum[SCALED_W+3:4];
  end

  logic                s3_valid;
  tag_t                s3_tag;
  logic [SCALED_W-1:0] s3_scaled;
  logic                s3_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_tag    <= s2_tag;
      s3_scaled <= scaled;
      s3_zero   <= s2_zero || below;
    end
  end

  // ---- stage 3: divide by the floor ----
  logic [RecMulW-1:0] q_prod;
  logic [QuotW-1:0]   quot;
  logic [LEVEL_W-1:0] height;

  always_comb begin
    q_prod = RecMulW'(s3_scaled) * RecMulW'(recip_tab[floor_db]);
    quot   = q_prod[RecMulW-1:RECIP_SHIFT];
    if (s3_zero) begin
      height = '0;
    end else if (quot > QuotW'(FULL_LEVEL)) begin
      height = FULL_LEVEL;
    end else begin
      height = quot[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag <= s3_tag;
      fresh   <= height;
    end
  end

endmodule

### design/lmph_state.sv
// ----------------------------------------------------------------------------
// lmph_state: per-channel bar and peak-hold state
// Read-modify-write of one channel per beat: bar fall over elapsed time,
// rise to the fresh height, peak capture and hold expiry.
// ----------------------------------------------------------------------------
module lmph_state #(
  parameter int CHANNELS = lmph_pkg::DEF_CHANNELS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  lmph_pkg::tag_t               in_tag,
  input  logic [lmph_pkg::LEVEL_W-1:0] fresh,
  input  lmph_pkg::cfg_t               cfg,
  output logic                         out_valid,
  output lmph_pkg::meter_t             out_meter
);
  import lmph_pkg::*;

  // only the channels a 3-bit field can reach ever hold state
  localparam int Slots = (CHANNELS < 2**CHAN_W) ? CHANNELS : 2**CHAN_W;
  localparam int SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int FallW = RATE_W + TIME_W;

  logic [SlotW-1:0] chan_map [2**CHAN_W];

  for (genvar gc = 0; gc < 2**CHAN_W; gc++) begin : g_map
    assign chan_map[gc] = SlotW'(gc % CHANNELS);
  end

  logic [LEVEL_W-1:0] level_store      [Slots];
  logic [LEVEL_W-1:0] peak_store       [Slots];
  logic [TIME_W-1:0]  peak_start_store [Slots];
  logic [TIME_W-1:0]  last_time_store  [Slots];
  logic [Slots-1:0]   peak_active;
  logic [Slots-1:0]   seen_before;

  logic [SlotW-1:0]      c;
  logic [TIME_W-1:0]     now;
  logic                  seen_c;
  logic [LEVEL_W-1:0]    lvl_old;
  logic [LEVEL_W-1:0]    peak_old;
  logic [TIME_W-1:0]     start_old;
  logic [TIME_W-1:0]     dt;
  logic [FallW-1:0]      fall;
  logic [FallW-11:0]     fall_lvl;
  logic [LEVEL_W-1:0]    decayed;
  logic [LEVEL_W-1:0]    lvl_next;
  logic                  expired;
  logic                  take;
  logic [LEVEL_W-1:0]    peak_next;
  logic                  active_next;
  logic [TIME_W-1:0]     start_next;
  logic                  visible;

  always_comb begin
    c         = chan_map[in_tag.chan];
    now       = in_tag.now_ms;
    seen_c    = seen_before[c];
    // level of an unseen channel is its reset value
    lvl_old   = seen_c ? level_store[c] : '0;
    peak_old  = peak_store[c];
    start_old = peak_start_store[c];

    dt       = (seen_c && now > last_time_store[c]) ? now - last_time_store[c] : '0;
    fall     = FallW'(cfg.fall_rate) * FallW'(dt);
    fall_lvl = fall[FallW-1:10];
    decayed  = (fall_lvl >= (FallW-10)'(lvl_old)) ? '0 : lvl_old - fall_lvl[LEVEL_W-1:0];
    lvl_next = (fresh > decayed) ? fresh : decayed;

    // an inactive peak (also any unseen channel) is always replaced
    expired = !peak_active[c] ||
              (now >= start_old && (now - start_old) > TIME_W'(cfg.peak_hold_ms));
    take    = (fresh >= peak_old) || expired;

    peak_next   = take ? fresh : peak_old;
    active_next = take ? (fresh != '0) : peak_active[c];
    start_next  = take ? ((fresh != '0) ? now : '0) : start_old;

    visible = active_next &&
              (now < start_next || (now - start_next) < TIME_W'(cfg.peak_hold_ms));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_active <= '0;
      seen_before <= '0;
    end else if (en && in_valid) begin
      peak_active[c] <= active_next;
      seen_before[c] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      level_store[c]      <= lvl_next;
      peak_store[c]       <= peak_next;
      peak_start_store[c] <= start_next;
      last_time_store[c]  <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_meter.chan    <= in_tag.chan;
      out_meter.bar     <= lvl_next;
      out_meter.peak    <= peak_next;
      out_meter.visible <= visible;
    end
  end

endmodule

### design/lmph_seg.sv
// ----------------------------------------------------------------------------
// lmph_seg: segment counts and result register
// Lit segment count and peak marker segment from the bar and peak heights.
// ----------------------------------------------------------------------------
module lmph_seg #(
  parameter int SEGMENTS = lmph_pkg::DEF_SEGMENTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  lmph_pkg::meter_t  in_meter,
  output logic              out_valid,
  output lmph_pkg::result_t out_res
);
  import lmph_pkg::*;

  localparam int ProdW = LEVEL_W + $clog2(SEGMENTS + 1) + 1;
  localparam int CntW  = ProdW - 12;

  logic [CntW-1:0] lit;
  logic [CntW-1:0] pr;
  logic [CntW-1:0] pseg;

  always_comb begin
    lit = CntW'((ProdW'(in_meter.bar) * ProdW'(SEGMENTS) + ProdW'(2048)) >> 12);
    pr  = CntW'((ProdW'(in_meter.peak) * ProdW'(SEGMENTS) + ProdW'(2048)) >> 12);
    if (!in_meter.visible || pr == '0) begin
      pseg = '0;
    end else if (pr - CntW'(1) > CntW'(SEGMENTS - 1)) begin
      pseg = CntW'(SEGMENTS - 1);
    end else begin
      pseg = pr - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res.chan     <= in_meter.chan;
      out_res.bar      <= in_meter.bar;
      out_res.peak     <= in_meter.peak;
      out_res.lit      <= lit[SEG_W-1:0];
      out_res.peak_seg <= pseg[SEG_W-1:0];
      out_res.visible  <= in_meter.visible;
    end
  end

endmodule

### design/log_level_meter_peak_hold.sv
// ----------------------------------------------------------------------------
// log_level_meter_peak_hold: multi-channel LED level meter with peak hold
//
// samples (sink): one beat per sample: channel, now_ms, amplitude.
// meter (source): one beat per sample with that channel's bar level, held
//   peak, lit segment count, peak marker segment and marker visibility.
// cfg (sink): register writes, ready whenever rst is low; index 0 fall_rate,
//   1 peak_hold_ms, 2 floor_db, other indexes ignored. Write only while idle.
//
// Path: a sample accepted on samples passes the input register, three
// height stages, the channel state update and the segment/result register
// before it shows on meter. Throughput: one sample per cycle while meter is
// not stalled, including back-to-back samples on the same channel, since the
// channel state is read and written in a single stage.
// The whole pipeline advances when the result register is empty or being
// taken; while meter is stalled samples.ready is low and all stages hold.
// Reset: registers return to their defaults (8389, 1500, 48), all channels
// return to no sample seen and no peak held; the pipeline empties and both
// samples.ready and cfg.ready stay low while rst is high.
// ----------------------------------------------------------------------------
module log_level_meter_peak_hold #(
  parameter int CHANNELS        = lmph_pkg::DEF_CHANNELS,
  parameter int SEGMENTS        = lmph_pkg::DEF_SEGMENTS,
  parameter int LOG_TABLE_DEPTH = lmph_pkg::DEF_LOG_TABLE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  lmph_sample_if.sink  samples,
  lmph_meter_if.source meter,
  lmph_cfg_if.sink     cfg
);
  import lmph_pkg::*;

  // ---- configuration registers ----
  cfg_t regs;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.fall_rate    <= RESET_FALL_RATE;
      regs.peak_hold_ms <= RESET_PEAK_HOLD;
      regs.floor_db     <= RESET_FLOOR_DB;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_FALL_RATE: regs.fall_rate    <= cfg.data[RATE_W-1:0];
        REG_PEAK_HOLD: regs.peak_hold_ms <= cfg.data[HOLD_W-1:0];
        REG_FLOOR_DB:  regs.floor_db     <= cfg.data[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- pipeline advance: result register free or draining ----
  logic adv;
  assign adv           = !meter.valid || meter.ready;
  // no beat is taken while reset holds the input register empty
  assign samples.ready = adv && !rst;

  // ---- input register ----
  logic             st1_valid;
  tag_t             st1_tag;
  logic [AMP_W-1:0] st1_amp;

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
    end else if (adv) begin
      st1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st1_tag.chan   <= samples.channel;
      st1_tag.now_ms <= samples.now_ms;
      st1_amp        <= samples.amplitude;
    end
  end

  // ---- amplitude to fresh height ----
  logic               ht_valid;
  tag_t               ht_tag;
  logic [LEVEL_W-1:0] ht_fresh;

  lmph_height #(
    .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
  ) u_height (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (st1_valid),
    .in_tag    (st1_tag),
    .amplitude (st1_amp),
    .floor_db  (regs.floor_db),
    .out_valid (ht_valid),
    .out_tag   (ht_tag),
    .fresh     (ht_fresh)
  );

  // ---- channel state update ----
  logic   st_valid;
  meter_t st_meter;

  lmph_state #(
    .CHANNELS (CHANNELS)
  ) u_state (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (ht_valid),
    .in_tag    (ht_tag),
    .fresh     (ht_fresh),
    .cfg       (regs),
    .out_valid (st_valid),
    .out_meter (st_meter)
  );

  // ---- segments and result register ----
  logic    res_valid;
  result_t res;

  lmph_seg #(
    .SEGMENTS (SEGMENTS)
  ) u_seg (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (st_valid),
    .in_meter  (st_meter),
    .out_valid (res_valid),
    .out_res   (res)
  );

  assign meter.valid        = res_valid;
  assign meter.channel_out  = res.chan;
  assign meter.bar_level    = res.bar;
  assign meter.peak_level   = res.peak;
  assign meter.lit_segments = res.lit;
  assign meter.peak_segment = res.peak_seg;
  assign meter.peak_visible = res.visible;

endmodule
